// ===== design/hng_pkg.sv =====
// ----------------------------------------------------------------------------
// hng_pkg: shared types and constants of the heightmap normal generator
// Widths, register indexes and the record passed from front to back.
// ----------------------------------------------------------------------------
package hng_pkg;

   localparam int MAX_SIDE   = 1024;
   localparam int COL_W      = $clog2(MAX_SIDE);
   localparam int SIZE_W     = 11;
   localparam int SCALE_W    = 16;
   localparam int SAMPLE_W   = 8;
   localparam int CSR_W      = 16;
   localparam int NRM_W      = 16;
   localparam int NY_W       = 15;
   localparam int Q_W        = 15;
   localparam int MAG_W      = 24;
   localparam int MAG2_W     = 2 * MAG_W;
   localparam int SQ_W       = 50;
   localparam int RES_W      = 88;
   localparam int FRAC_SH    = 30;
   localparam int Y_TERM_SQ  = 512 * 512;
   localparam int Y_TERM_SH  = 48;
   localparam int Q_ONE      = 16384;
   localparam int NBANK      = 3;
   localparam int BANK_W     = 2;
   localparam int NLANE      = 3;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
   localparam int OUT_W      = 48;

   // register indexes
   localparam logic REG_IMAGE_SIZE   = 1'b0;
   localparam logic REG_HEIGHT_SCALE = 1'b1;

   // lane order in the normalizer
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   // neighbor bytes of one pixel, zeros already applied outside the image
   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic [SAMPLE_W-1:0] up;
      logic [SAMPLE_W-1:0] down;
      logic                last;
   } pix_type;

endpackage

// ===== design/hng_front.sv =====
// ----------------------------------------------------------------------------
// hng_front: raster counters, line banks and neighbor gathering
// Three rotating row banks hold the two previous rows; each sample of row 1
// and up yields one neighbor record for the pixel one row above.
// ----------------------------------------------------------------------------
module hng_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [hng_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [hng_pkg::SAMPLE_W-1:0] req_tdata,
   output logic                         push_valid,
   output hng_pkg::pix_type             push_data,
   input  logic                         fifo_ready,
   output logic [hng_pkg::SCALE_W-1:0]  scale
);

   logic [hng_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [hng_pkg::SCALE_W-1:0]  scale_ff, scale_in;
   logic [hng_pkg::COL_W-1:0]    col_ff, col_in;
   logic [hng_pkg::SIZE_W-1:0]   row_ff, row_in;
   logic [hng_pkg::BANK_W-1:0]   wbank_ff, wbank_in;
   logic [hng_pkg::SAMPLE_W-1:0] rt_d1_ff, rt_d2_ff, col0_hold_ff, col0_prev_ff;
   logic [hng_pkg::SAMPLE_W-1:0] bank_mem [hng_pkg::NBANK][hng_pkg::MAX_SIDE];
   logic [hng_pkg::SAMPLE_W-1:0] rd_q_ff [hng_pkg::NBANK];
   logic                         byp_ff [hng_pkg::NBANK];
   logic                         byp_in [hng_pkg::NBANK];
   logic [hng_pkg::SAMPLE_W-1:0] byp_data_ff;
   logic [hng_pkg::SAMPLE_W-1:0] bank_data [hng_pkg::NBANK];
   logic [hng_pkg::COL_W-1:0]    ra [hng_pkg::NBANK];
   logic [hng_pkg::BANK_W-1:0]   ctr_bank_in, ctr_bank, abv_bank;
   logic [hng_pkg::SIZE_W-1:0]   col_nx, v_size;
   logic                         accept, end_col, size_wr;
   logic [hng_pkg::SAMPLE_W-1:0] right_raw, up_raw;

   assign accept     = req_tvalid && fifo_ready;
   assign req_tready = fifo_ready;
   assign scale      = scale_ff;
   assign size_wr    = csr_we && (csr_index == hng_pkg::REG_IMAGE_SIZE);
   assign col_nx     = {1'b0, col_ff} + hng_pkg::SIZE_W'(1);
   assign end_col    = col_nx >= size_ff;

   // configuration writes, size clamped to the supported range
   always_comb begin
      v_size   = csr_wdata[hng_pkg::SIZE_W-1:0];
      size_in  = size_ff;
      scale_in = scale_ff;
      if (size_wr) begin
         if (v_size < hng_pkg::SIZE_W'(2)) size_in = hng_pkg::SIZE_W'(2);
         else if (v_size > hng_pkg::SIZE_W'(hng_pkg::MAX_SIDE))
            size_in = hng_pkg::SIZE_W'(hng_pkg::MAX_SIDE);
         else size_in = v_size;
      end
      if (csr_we && (csr_index == hng_pkg::REG_HEIGHT_SCALE)) begin
         scale_in = csr_wdata[hng_pkg::SCALE_W-1:0];
      end
   end

   // raster position and the bank that takes the current row
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      wbank_in = wbank_ff;
      if (size_wr) begin
         col_in   = '0;
         row_in   = '0;
         wbank_in = '0;
      end else if (accept) begin
         if (end_col) begin
            col_in = '0;
            if (row_ff == size_ff) row_in = '0;
            else row_in = row_ff + hng_pkg::SIZE_W'(1);
            if (row_ff == size_ff) wbank_in = '0;
            else if (wbank_ff == hng_pkg::BANK_W'(2)) wbank_in = '0;
            else wbank_in = wbank_ff + hng_pkg::BANK_W'(1);
         end else begin
            col_in = col_nx[hng_pkg::COL_W-1:0];
         end
      end
   end

   // bank roles: center is the row above, above is two rows up
   always_comb begin
      ctr_bank_in = (wbank_in == '0) ? hng_pkg::BANK_W'(2) : wbank_in - hng_pkg::BANK_W'(1);
      ctr_bank    = (wbank_ff == '0) ? hng_pkg::BANK_W'(2) : wbank_ff - hng_pkg::BANK_W'(1);
      abv_bank    = (wbank_ff == hng_pkg::BANK_W'(2)) ? '0 : wbank_ff + hng_pkg::BANK_W'(1);
      for (int b = 0; b < hng_pkg::NBANK; b++) begin
         if (ctr_bank_in == hng_pkg::BANK_W'(b)) ra[b] = col_in + hng_pkg::COL_W'(1);
         else ra[b] = col_in;
         byp_in[b]    = accept && (wbank_ff == hng_pkg::BANK_W'(b)) && (ra[b] == col_ff);
         bank_data[b] = byp_ff[b] ? byp_data_ff : rd_q_ff[b];
      end
      right_raw = bank_data[ctr_bank];
      up_raw    = bank_data[abv_bank];
   end

   // bank storage, read data prefetched for the next position
   always_ff @(posedge clock) begin
      for (int b = 0; b < hng_pkg::NBANK; b++) begin
         if (accept && (wbank_ff == hng_pkg::BANK_W'(b))) begin
            bank_mem[b][col_ff] <= req_tdata;
         end
         rd_q_ff[b] <= bank_mem[b][ra[b]];
         byp_ff[b]  <= byp_in[b];
      end
      byp_data_ff <= req_tdata;
   end

   // neighbor record
   always_comb begin
      push_valid     = accept && (row_ff != '0);
      if (col_ff == '0) push_data.left = '0;
      else if (col_ff == hng_pkg::COL_W'(1)) push_data.left = col0_prev_ff;
      else push_data.left = rt_d2_ff;
      push_data.right = end_col ? '0 : right_raw;
      push_data.up    = (row_ff >= hng_pkg::SIZE_W'(2)) ? up_raw : '0;
      push_data.down  = (row_ff < size_ff) ? req_tdata : '0;
      push_data.last  = (row_ff == size_ff) && end_col;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= hng_pkg::SIZE_W'(256);
         scale_ff <= hng_pkg::SCALE_W'(256);
         col_ff   <= '0;
         row_ff   <= '0;
         wbank_ff <= '0;
      end else begin
         size_ff  <= size_in;
         scale_ff <= scale_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         wbank_ff <= wbank_in;
      end
   end

   // left neighbor history
   always_ff @(posedge clock) begin
      if (accept) begin
         rt_d1_ff <= right_raw;
         rt_d2_ff <= rt_d1_ff;
         if (col_ff == '0) col0_hold_ff <= req_tdata;
         if (col_ff == hng_pkg::COL_W'(1)) col0_prev_ff <= col0_hold_ff;
      end
   end

endmodule

// ===== design/hng_fifo.sv =====
// ----------------------------------------------------------------------------
// hng_fifo: short queue between front and back
// Register-based FIFO of neighbor records, push and pop in the same cycle.
// ----------------------------------------------------------------------------
module hng_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hng_pkg::pix_type push_data,
   output logic             ready,
   input  logic             pop,
   output logic             pop_valid,
   output hng_pkg::pix_type pop_data
);

   hng_pkg::pix_type                slot_ff [hng_pkg::FIFO_DEPTH];
   logic [hng_pkg::FIFO_PTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [hng_pkg::FIFO_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            full;

   assign full      = cnt_ff == hng_pkg::FIFO_CNT_W'(hng_pkg::FIFO_DEPTH);
   assign ready     = !full;
   assign pop_valid = cnt_ff != '0;
   assign pop_data  = slot_ff[rp_ff];

   // pointers and fill level
   always_comb begin
      wp_in  = push ? wp_ff + hng_pkg::FIFO_PTR_W'(1) : wp_ff;
      rp_in  = pop ? rp_ff + hng_pkg::FIFO_PTR_W'(1) : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + hng_pkg::FIFO_CNT_W'(1);
      else if (!push && pop) cnt_in = cnt_ff - hng_pkg::FIFO_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_data;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= hng_pkg::FIFO_CNT_W'(hng_pkg::FIFO_DEPTH))
      else $error("fifo level above depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full fifo");
`endif

endmodule

// ===== design/hng_back.sv =====
// ----------------------------------------------------------------------------
// hng_back: gradient, squaring and unit-vector normalizer pipeline
// Scaled differences are squared, then each component is found one
// quotient bit per stage by an exact square-compare recurrence.
// ----------------------------------------------------------------------------
module hng_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hng_pkg::SCALE_W-1:0]   scale,
   input  logic                          pop_valid,
   input  hng_pkg::pix_type              pop_data,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [hng_pkg::OUT_W-1:0]     rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int NST = hng_pkg::Q_W + 1;

   logic en;

   // stage 1: scaled absolute differences
   logic                        v1_ff, nx1_ff, nz1_ff, last1_ff;
   logic [hng_pkg::MAG_W-1:0]   mx_ff, mz_ff;
   logic [hng_pkg::SAMPLE_W-1:0] dxm, dzm;
   logic                        nx_in, nz_in;

   // stage 2: squares
   logic                        v2_ff, nx2_ff, nz2_ff, last2_ff;
   logic [hng_pkg::MAG2_W-1:0]  mx2_ff, mz2_ff;

   // recurrence stages, index 0 holds the initial residuals
   logic                        vr_ff [NST];
   logic                        nxr_ff [NST];
   logic                        nzr_ff [NST];
   logic                        lr_ff [NST];
   logic [hng_pkg::SQ_W-1:0]    sq_ff [NST];
   logic [hng_pkg::RES_W-1:0]   rr_ff [NST][hng_pkg::NLANE];
   logic [hng_pkg::RES_W-1:0]   pp_ff [NST][hng_pkg::NLANE];
   logic [hng_pkg::Q_W-1:0]     qq_ff [NST][hng_pkg::NLANE];
   logic [hng_pkg::RES_W-1:0]   rr_in [NST][hng_pkg::NLANE];
   logic [hng_pkg::RES_W-1:0]   pp_in [NST][hng_pkg::NLANE];
   logic [hng_pkg::Q_W-1:0]     qq_in [NST][hng_pkg::NLANE];
   logic [hng_pkg::SQ_W-1:0]    sq_in;

   // output register
   logic                        rsp_valid_ff;
   logic [hng_pkg::OUT_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff;
   logic [hng_pkg::NRM_W-1:0]   nrm_x, nrm_z;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign pop        = en && pop_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // sign and magnitude of the central differences
   always_comb begin
      nx_in = pop_data.left < pop_data.right;
      nz_in = pop_data.up < pop_data.down;
      dxm   = nx_in ? pop_data.right - pop_data.left : pop_data.left - pop_data.right;
      dzm   = nz_in ? pop_data.down - pop_data.up : pop_data.up - pop_data.down;
   end

   // initial residuals (A - sq with u = -1, and P = -sq), then one quotient
   // bit per stage: try q + 2^k, keep it when residual stays >= 0
   always_comb begin
      logic [hng_pkg::RES_W-1:0] cand;
      logic [hng_pkg::RES_W-1:0] sqw;
      sq_in = hng_pkg::SQ_W'(mx2_ff) + hng_pkg::SQ_W'(mz2_ff)
            + hng_pkg::SQ_W'(hng_pkg::Y_TERM_SQ);
      rr_in[0][hng_pkg::LANE_X] = (hng_pkg::RES_W'(mx2_ff) << hng_pkg::FRAC_SH)
                                - hng_pkg::RES_W'(sq_in);
      rr_in[0][hng_pkg::LANE_Y] = (hng_pkg::RES_W'(1) << hng_pkg::Y_TERM_SH)
                                - hng_pkg::RES_W'(sq_in);
      rr_in[0][hng_pkg::LANE_Z] = (hng_pkg::RES_W'(mz2_ff) << hng_pkg::FRAC_SH)
                                - hng_pkg::RES_W'(sq_in);
      for (int l = 0; l < hng_pkg::NLANE; l++) begin
         pp_in[0][l] = '0 - hng_pkg::RES_W'(sq_in);
         qq_in[0][l] = '0;
      end
      for (int j = 0; j < NST - 1; j++) begin
         sqw = hng_pkg::RES_W'(sq_ff[j]);
         for (int l = 0; l < hng_pkg::NLANE; l++) begin
            cand = rr_ff[j][l] - (pp_ff[j][l] << (hng_pkg::Q_W - 1 - j + 2))
                 - (sqw << (2 * (hng_pkg::Q_W - 1 - j) + 2));
            if (!cand[hng_pkg::RES_W-1]) begin
               rr_in[j+1][l] = cand;
               pp_in[j+1][l] = pp_ff[j][l] + (sqw << (hng_pkg::Q_W - 1 - j + 1));
               qq_in[j+1][l] = qq_ff[j][l] | (hng_pkg::Q_W'(1) << (hng_pkg::Q_W - 1 - j));
            end else begin
               rr_in[j+1][l] = rr_ff[j][l];
               pp_in[j+1][l] = pp_ff[j][l];
               qq_in[j+1][l] = qq_ff[j][l];
            end
         end
      end
   end

   // signed Q1.14 packing, tdata = x | y | z from bit 0 up
   always_comb begin
      logic [hng_pkg::Q_W-1:0] qx, qz;
      qx = qq_ff[NST-1][hng_pkg::LANE_X];
      qz = qq_ff[NST-1][hng_pkg::LANE_Z];
      nrm_x = (nxr_ff[NST-1] && (qx != '0)) ? '0 - {1'b0, qx} : {1'b0, qx};
      nrm_z = (nzr_ff[NST-1] && (qz != '0)) ? '0 - {1'b0, qz} : {1'b0, qz};
      rsp_data_in = {1'b0, nrm_z, qq_ff[NST-1][hng_pkg::LANE_Y], nrm_x};
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < NST; j++) vr_ff[j] <= 1'b0;
      end else if (en) begin
         v1_ff        <= pop_valid;
         v2_ff        <= v1_ff;
         vr_ff[0]     <= v2_ff;
         for (int j = 1; j < NST; j++) vr_ff[j] <= vr_ff[j-1];
         rsp_valid_ff <= vr_ff[NST-1];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff    <= hng_pkg::MAG_W'(scale) * hng_pkg::MAG_W'(dxm);
         mz_ff    <= hng_pkg::MAG_W'(scale) * hng_pkg::MAG_W'(dzm);
         nx1_ff   <= nx_in;
         nz1_ff   <= nz_in;
         last1_ff <= pop_data.last;
         mx2_ff   <= hng_pkg::MAG2_W'(mx_ff) * hng_pkg::MAG2_W'(mx_ff);
         mz2_ff   <= hng_pkg::MAG2_W'(mz_ff) * hng_pkg::MAG2_W'(mz_ff);
         nx2_ff   <= nx1_ff;
         nz2_ff   <= nz1_ff;
         last2_ff <= last1_ff;
         sq_ff[0]  <= sq_in;
         nxr_ff[0] <= nx2_ff;
         nzr_ff[0] <= nz2_ff;
         lr_ff[0]  <= last2_ff;
         for (int j = 1; j < NST; j++) begin
            sq_ff[j]  <= sq_ff[j-1];
            nxr_ff[j] <= nxr_ff[j-1];
            nzr_ff[j] <= nzr_ff[j-1];
            lr_ff[j]  <= lr_ff[j-1];
         end
         for (int j = 0; j < NST; j++) begin
            for (int l = 0; l < hng_pkg::NLANE; l++) begin
               rr_ff[j][l] <= rr_in[j][l];
               pp_ff[j][l] <= pp_in[j][l];
               qq_ff[j][l] <= qq_in[j][l];
            end
         end
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= lr_ff[NST-1];
      end
   end

`ifndef SYNTHESIS
   a_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[30:16] <= hng_pkg::NY_W'(hng_pkg::Q_ONE)))
      else $error("normal_y above one");
   a_x_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[15]) |-> (rsp_data_ff[15:0] >= 16'hC000))
      else $error("normal_x below minus one");
`endif

endmodule

// ===== design/heightmap_normal_generator.sv =====
// ----------------------------------------------------------------------------
// heightmap_normal_generator: unit normals of a square height image
// Channel  Dir  Payload (low bit first)
// req      in   tdata[7:0] height_sample
// rsp      out  tdata[15:0] normal_x, [30:16] normal_y, [46:31] normal_z;
//               tlast last_pixel
// csr      in   index 0 image_size, 1 height_scale; write on csr_we
// One sample transfer per clock while req_tready is high; the line banks
// are single-read per bank and the normalizer takes one quotient bit per
// stage, fully pipelined. A result follows the sample of the row below.
// Synchronous reset; the line banks need no clearing pass.
// A stalled rsp holds the back pipeline; the 4-entry queue then fills and
// req_tready drops.
// ----------------------------------------------------------------------------
module heightmap_normal_generator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [hng_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [hng_pkg::SAMPLE_W-1:0] req_tdata,   // [7:0] height_sample
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [hng_pkg::OUT_W-1:0]    rsp_tdata,   // x, y, z, zero pad
   output logic                         rsp_tlast
);

   hng_pkg::pix_type            push_data, pop_data;
   logic                        push_valid, fifo_ready, pop, pop_valid;
   logic [hng_pkg::SCALE_W-1:0] scale;

   hng_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_data  (push_data),
      .fifo_ready (fifo_ready),
      .scale      (scale)
   );

   hng_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .ready     (fifo_ready),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   hng_back u_back (
      .clock      (clock),
      .reset      (reset),
      .scale      (scale),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== verif/tb_heightmap_normal_generator.sv =====
// ----------------------------------------------------------------------------
// tb_heightmap_normal_generator: self-checking bench for the normal generator
// Streams square height images through the block at several sizes and
// scales, predicts each Q1.14 normal in the bench and checks every rsp
// transfer in order. Both stream sides idle and stall at random per phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_heightmap_normal_generator;

   typedef struct {
      logic [15:0] nx;
      logic [14:0] ny;
      logic [15:0] nz;
      logic        last;
   } normal_type;

   // predictor plus in-order result store
   class normal_scoreboard;
      int unsigned  side, scale, col, row;
      byte unsigned line_up[hng_pkg::MAX_SIDE];
      byte unsigned line_mid[hng_pkg::MAX_SIDE];
      normal_type   pending_normals[$];
      int           errors, checked;

      function new();
         side = 256; scale = 256; col = 0; row = 0;
         errors = 0; checked = 0;
      endfunction

      function void write_reg(logic idx, int unsigned value);
         int unsigned v;
         if (idx == hng_pkg::REG_IMAGE_SIZE) begin
            v = value & 11'h7FF;
            if (v < 2) v = 2;
            if (v > hng_pkg::MAX_SIDE) v = hng_pkg::MAX_SIDE;
            side = v; col = 0; row = 0;
         end else begin
            scale = value & 16'hFFFF;
         end
      endfunction

      function int unsigned samples_left();
         return side * (side + 1) - (row * side + col);
      endfunction

      // round(16384 * mag / sqrt(sq)) by bisection on squares
      function automatic int unsigned unit_q(longint unsigned mag, longint unsigned sq);
         logic [127:0]    lhs, rhs;
         int unsigned     lo, hi, mid;
         longint unsigned t;
         lo = 0; hi = hng_pkg::Q_ONE;
         lhs = (128'(mag) << 15) * (128'(mag) << 15);
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * longint'(mid) - 1;
            rhs = 128'(t * t) * 128'(sq);
            if (rhs <= lhs) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      function void note_sample(byte unsigned s);
         int unsigned     c, l, r, u, d, qx, qy, qz;
         longint unsigned mx, mz, sq;
         normal_type      n;
         c = (col >= side) ? 0 : col;
         if (row == 0) begin
            line_mid[c] = s;
            col = c + 1;
            if (col >= side) begin col = 0; row = 1; end
            return;
         end
         l = (c > 0) ? line_up[c-1] : 0;
         r = (c + 1 < side) ? line_mid[c+1] : 0;
         u = (row >= 2) ? line_up[c] : 0;
         d = (row < side) ? s : 0;
         line_up[c] = line_mid[c];
         line_mid[c] = s;
         mx = longint'(scale) * ((l < r) ? r - l : l - r);
         mz = longint'(scale) * ((u < d) ? d - u : u - d);
         sq = mx * mx + mz * mz + hng_pkg::Y_TERM_SQ;
         qx = unit_q(mx, sq);
         qy = unit_q(512, sq);
         qz = unit_q(mz, sq);
         n.nx = (l < r) ? 16'(-int'(qx)) : 16'(qx);
         n.ny = 15'(qy);
         n.nz = (u < d) ? 16'(-int'(qz)) : 16'(qz);
         n.last = (row == side) && (c + 1 == side);
         pending_normals.push_back(n);
         col = c + 1;
         if (col >= side) begin
            col = 0;
            row++;
            if (row > side) row = 0;
         end
      endfunction

      function void check_normal(normal_type got);
         normal_type want;
         checked++;
         if (pending_normals.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected normal x=%0d y=%0d z=%0d last=%0b",
                                       $signed(got.nx), got.ny, $signed(got.nz), got.last);
            return;
         end
         want = pending_normals.pop_front();
         if (want.nx !== got.nx || want.ny !== got.ny || want.nz !== got.nz ||
             want.last !== got.last) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: normal %0d exp x=%0d y=%0d z=%0d last=%0b got x=%0d y=%0d z=%0d last=%0b",
                        checked, $signed(want.nx), want.ny, $signed(want.nz), want.last,
                        $signed(got.nx), got.ny, $signed(got.nz), got.last);
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 40;
   localparam int ITEMS       = 1700;

   logic                         clock, reset;
   logic                         csr_we, csr_index;
   logic [hng_pkg::CSR_W-1:0]    csr_wdata;
   logic                         req_tvalid, req_tready;
   logic [hng_pkg::SAMPLE_W-1:0] req_tdata;
   logic                         rsp_tvalid, rsp_tready;
   logic [hng_pkg::OUT_W-1:0]    rsp_tdata;
   logic                         rsp_tlast;

   normal_scoreboard sb = new();
   int unsigned      samples_in, cycles, send_idle_pct, stall_pct, phases;

   heightmap_normal_generator dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // accepted transfers on both channels, plus the watchdog
   always @(posedge clock) begin
      cycles++;
      if (!reset && req_tvalid && req_tready) begin
         sb.note_sample(req_tdata);
         samples_in++;
      end
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_normal('{rsp_tdata[15:0], rsp_tdata[30:16], rsp_tdata[46:31], rsp_tlast});
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   task automatic send_sample(byte unsigned s);
      int unsigned target;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = s;
      target = samples_in + 1;
      do @(negedge clock); while (samples_in != target);
      req_tvalid = 1'b0;
   endtask

   task automatic drain();
      while (sb.pending_normals.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, int unsigned value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = hng_pkg::CSR_W'(value);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic byte unsigned pick_height();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(100, 110));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic set_mode(int unsigned k);
      case (k % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 71; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 71; end
         default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
   endtask

   initial begin
      int unsigned  n, count, sz;
      byte unsigned steep[6];
      steep = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd7, 8'd9};
      samples_in = 0; cycles = 0; send_idle_pct = 0; stall_pct = 0; phases = 0;
      reset = 1'b1; csr_we = 1'b0; csr_index = hng_pkg::REG_IMAGE_SIZE; csr_wdata = '0;
      req_tvalid = 1'b0; req_tdata = '0; rsp_tready = 1'b1;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // smallest image, full scale, steepest slopes (size below range clamps)
      write_csr(hng_pkg::REG_IMAGE_SIZE, 0);
      write_csr(hng_pkg::REG_HEIGHT_SCALE, 16'hFFFF);
      foreach (steep[i]) send_sample(steep[i]);
      drain();
      // zero scale gives flat normals; size one clamps up
      write_csr(hng_pkg::REG_IMAGE_SIZE, 1);
      write_csr(hng_pkg::REG_HEIGHT_SCALE, 0);
      repeat (6) send_sample(8'($urandom));
      drain();
      // widest image (size above range clamps): row 0 then part of row 1
      write_csr(hng_pkg::REG_IMAGE_SIZE, 2047);
      write_csr(hng_pkg::REG_HEIGHT_SCALE, 256);
      for (int i = 0; i < hng_pkg::MAX_SIDE + 20; i++)
         send_sample((i % 3 == 0) ? 8'd255 : ((i % 3 == 1) ? 8'd0 : 8'($urandom)));
      drain();
      // abandon the wide image so the random phases start from row 0
      write_csr(hng_pkg::REG_IMAGE_SIZE, 2);

      // random images, mostly whole; cut short ones resume rescaled or restart resized
      while (samples_in < ITEMS) begin
         set_mode(phases++);
         if (sb.row != 0 || sb.col != 0) begin
            if ($urandom_range(1)) write_csr(hng_pkg::REG_HEIGHT_SCALE, $urandom_range(1, 700));
            else write_csr(hng_pkg::REG_IMAGE_SIZE, $urandom_range(2, 12));
         end else begin
            sz = ($urandom_range(7) == 0) ? $urandom_range(13, 30) : $urandom_range(2, 10);
            write_csr(hng_pkg::REG_IMAGE_SIZE, sz);
            case ($urandom_range(5))
               0: write_csr(hng_pkg::REG_HEIGHT_SCALE, 0);
               1: write_csr(hng_pkg::REG_HEIGHT_SCALE, 16'hFFFF);
               2: write_csr(hng_pkg::REG_HEIGHT_SCALE, $urandom_range(65535));
               default: write_csr(hng_pkg::REG_HEIGHT_SCALE, $urandom_range(1, 700));
            endcase
         end
         n = sb.samples_left();
         count = ($urandom_range(4) == 0) ? $urandom_range(1, n) : n;
         if (samples_in + count > ITEMS) count = ITEMS - samples_in;
         for (int i = 0; i < count; i++) send_sample(pick_height());
         drain();
      end

      $display("run covered %0d sample transfers and %0d normals over %0d phases",
               samples_in, sb.checked, phases + 3);
      $display("sizes 2..30 plus 1024, scales 0..65535, idle and stall mixes");
      if (sb.errors == 0 && sb.pending_normals.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d normals missing", sb.errors, sb.pending_normals.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/hng_pkg.sv
design/hng_front.sv
design/hng_fifo.sv
design/hng_back.sv
design/heightmap_normal_generator.sv
verif/tb_heightmap_normal_generator.sv
